### rtl/core/ttc_pkg.sv
// Shared constants, types and tables for the tick count to calendar converter.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package ttc_pkg;

   localparam int TICK_W      = 64;
   localparam int RATE_W      = 30;
   localparam int RATE_RESET  = 1000000000;
   localparam int YEAR_SPAN   = 256;

   localparam int SECS_PER_MIN  = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_DAY  = 86400;
   localparam int DAYS_PER_BLK  = 1461;   // four years starting at 1970: 365,365,366,365

   // whole span from 1970: one leap year in every four, the first one at 1972
   localparam longint SPAN_DAYS = 365 * YEAR_SPAN + (YEAR_SPAN + 1) / 4;
   localparam longint SPAN_SECS = SPAN_DAYS * SECS_PER_DAY;

   localparam int SECS_W = $clog2(SPAN_SECS);
   localparam int DAYS_W = $clog2(SPAN_DAYS);
   localparam int SOD_W  = $clog2(SECS_PER_DAY);
   localparam int SOH_W  = $clog2(SECS_PER_HOUR);
   localparam int STEP_W = $clog2(TICK_W + 1);

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic start;
      logic leap;
      logic [8:0] doy;
   } mon_ctl_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
   } mon_stat_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### rtl/core/tick_count_to_calendar.sv
// Tick count to calendar date converter.
// Command channel: req_tick_count is taken at a clock edge with req_start high and
// busy low; busy drops in the cycle the result strobe is high.
// Config: csr_write_enable/csr_write_data load tick_rate (ticks per second, 0 acts as 1);
// write it only while busy is low. Reset sets tick_rate to 1e9.
// Result: one beat per request, rsp_strobe high for one cycle with all rsp_ fields.
// The receiver cannot stall; a new request may be issued in the cycle of the strobe.
// Sequencing: one shared bit-serial divider does all the work. Per request it
//   runs count / tick_rate over all TICK_W quotient bits, then, if in range,
//   /86400 over SECS_W bits, /1461 days over DAYS_W bits, /3600 over SOD_W bits
//   and /60 over SOH_W bits, each started when the one before is done. Out of
//   range the strobe follows the first division. The month walk overlaps the
//   hour and minute divisions.
// Counts at or past the end of the year span give rsp_out_of_range with zeroed
// calendar fields; rsp_leftover_ticks is always valid.
`default_nettype none

module tick_count_to_calendar (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_start,
   input  wire logic [ttc_pkg::TICK_W-1:0]  req_tick_count,
   output logic                             busy,
   input  wire logic                        csr_write_enable,
   input  wire logic [ttc_pkg::RATE_W-1:0]  csr_write_data,
   output logic                             rsp_strobe,
   output logic [8:0]                       rsp_years_since_1900,
   output logic [3:0]                       rsp_month_index,
   output logic [4:0]                       rsp_day_of_month,
   output logic [4:0]                       rsp_hour_of_day,
   output logic [5:0]                       rsp_minute_of_hour,
   output logic [5:0]                       rsp_second_of_minute,
   output logic [ttc_pkg::RATE_W-1:0]       rsp_leftover_ticks,
   output logic                             rsp_out_of_range
);
   import ttc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TICK = 3'd1;
   localparam logic [2:0] ST_SECS = 3'd2;
   localparam logic [2:0] ST_DAYS = 3'd3;
   localparam logic [2:0] ST_HOUR = 3'd4;
   localparam logic [2:0] ST_MIN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [RATE_W-1:0] rate_eff;

   div_ctl_type       div_ctl;
   logic [TICK_W-1:0] div_dividend;
   logic [RATE_W-1:0] div_divisor;
   logic              div_done;
   logic [TICK_W-1:0] div_quot;
   logic [RATE_W-1:0] div_rem;

   mon_ctl_type       mon_ctl;
   mon_stat_type      mon_stat;

   logic [RATE_W-1:0] rest_ff, rest_in;
   logic [SOD_W-1:0]  sod_ff, sod_in;
   logic [8:0]        years_ff, years_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        min_ff, min_in;
   logic [5:0]        sec_ff, sec_in;
   logic              oor_ff, oor_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [8:0]        rsp_years_ff;
   logic [3:0]        rsp_month_ff;
   logic [4:0]        rsp_day_ff;
   logic [4:0]        rsp_hour_ff;
   logic [5:0]        rsp_min_ff;
   logic [5:0]        rsp_sec_ff;
   logic [RATE_W-1:0] rsp_rest_ff;
   logic              rsp_oor_ff;

   // year within a four-year block; the third year (1972, 1976, ...) is leap
   logic [10:0]       blk_day;
   logic [1:0]        yib;
   logic [8:0]        doy;

   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign blk_day  = div_rem[10:0];

   always_comb begin
      priority if (blk_day < 11'd365) begin
         yib = 2'd0;
         doy = blk_day[8:0];
      end else if (blk_day < 11'd730) begin
         yib = 2'd1;
         doy = 9'(blk_day - 11'd365);
      end else if (blk_day < 11'd1096) begin
         yib = 2'd2;
         doy = 9'(blk_day - 11'd730);
      end else begin
         yib = 2'd3;
         doy = 9'(blk_day - 11'd1096);
      end
   end

   assign rate_in = csr_write_enable ? csr_write_data : rate_ff;

   always_comb begin
      state_in      = state_ff;
      div_ctl       = '0;
      div_dividend  = req_tick_count;
      div_divisor   = rate_eff;
      mon_ctl.start = 1'b0;
      mon_ctl.leap  = (yib == 2'd2);
      mon_ctl.doy   = doy;
      rest_in       = rest_ff;
      sod_in        = sod_ff;
      years_in      = years_ff;
      hour_in       = hour_ff;
      min_in        = min_ff;
      sec_in        = sec_ff;
      oor_in        = oor_ff;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(TICK_W);
               state_in      = ST_TICK;
            end
         end
         ST_TICK: begin
            div_divisor  = RATE_W'(SECS_PER_DAY);
            div_dividend = div_quot << (TICK_W - SECS_W);
            if (div_done) begin
               rest_in = div_rem;
               if (div_quot >= TICK_W'(SPAN_SECS)) begin
                  oor_in   = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  oor_in        = 1'b0;
                  div_ctl.start = 1'b1;
                  div_ctl.steps = STEP_W'(SECS_W);
                  state_in      = ST_SECS;
               end
            end
         end
         ST_SECS: begin
            div_divisor  = RATE_W'(DAYS_PER_BLK);
            div_dividend = div_quot << (TICK_W - DAYS_W);
            if (div_done) begin
               sod_in        = div_rem[SOD_W-1:0];
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(DAYS_W);
               state_in      = ST_DAYS;
            end
         end
         ST_DAYS: begin
            div_divisor  = RATE_W'(SECS_PER_HOUR);
            div_dividend = TICK_W'(sod_ff) << (TICK_W - SOD_W);
            if (div_done) begin
               years_in      = 9'd70 + {div_quot[6:0], 2'b00} + {7'd0, yib};
               mon_ctl.start = 1'b1;
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(SOD_W);
               state_in      = ST_HOUR;
            end
         end
         ST_HOUR: begin
            div_divisor  = RATE_W'(SECS_PER_MIN);
            div_dividend = TICK_W'(div_rem[SOH_W-1:0]) << (TICK_W - SOH_W);
            if (div_done) begin
               hour_in       = div_quot[4:0];
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(SOH_W);
               state_in      = ST_MIN;
            end
         end
         ST_MIN: begin
            if (div_done) begin
               min_in   = div_quot[5:0];
               sec_in   = div_rem[5:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!mon_stat.busy) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rate_ff       <= RATE_W'(RATE_RESET);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rate_ff       <= rate_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff  <= rest_in;
      sod_ff   <= sod_in;
      years_ff <= years_in;
      hour_ff  <= hour_in;
      min_ff   <= min_in;
      sec_ff   <= sec_in;
      oor_ff   <= oor_in;
      if (rsp_strobe_in) begin
         rsp_years_ff <= oor_ff ? '0 : years_ff;
         rsp_month_ff <= oor_ff ? '0 : mon_stat.month_index;
         rsp_day_ff   <= oor_ff ? '0 : mon_stat.day_of_month;
         rsp_hour_ff  <= oor_ff ? '0 : hour_ff;
         rsp_min_ff   <= oor_ff ? '0 : min_ff;
         rsp_sec_ff   <= oor_ff ? '0 : sec_ff;
         rsp_rest_ff  <= rest_ff;
         rsp_oor_ff   <= oor_ff;
      end
   end

   ttc_serdiv u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   ttc_month u_month (
      .clock (clock),
      .reset (reset),
      .ctl   (mon_ctl),
      .stat  (mon_stat)
   );

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_years_since_1900 = rsp_years_ff;
   assign rsp_month_index      = rsp_month_ff;
   assign rsp_day_of_month     = rsp_day_ff;
   assign rsp_hour_of_day      = rsp_hour_ff;
   assign rsp_minute_of_hour   = rsp_min_ff;
   assign rsp_second_of_minute = rsp_sec_ff;
   assign rsp_leftover_ticks   = rsp_rest_ff;
   assign rsp_out_of_range     = rsp_oor_ff;

endmodule

`default_nettype wire

### rtl/core/ttc_serdiv.sv
// Restoring divider, one quotient bit per cycle, shared by every division step.
// Depends on ttc_pkg. Dividend arrives left-aligned so only the used bits are run;
// divisor is held from start to done.
`default_nettype none

module ttc_serdiv (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ttc_pkg::div_ctl_type      ctl,
   input  wire logic [ttc_pkg::TICK_W-1:0] dividend,
   input  wire logic [ttc_pkg::RATE_W-1:0] divisor,
   output logic                           done,
   output logic [ttc_pkg::TICK_W-1:0]     quotient,
   output logic [ttc_pkg::RATE_W-1:0]     remainder
);
   import ttc_pkg::*;

   logic [TICK_W-1:0] q_ff, q_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, q_ff[TICK_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         q_in   = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = ctl.steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[TICK_W-2:0], ge};
         rem_in = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/ttc_month.sv
// Month stepper: walks the month table one month per cycle from a day of year.
// Depends on ttc_pkg (month_len, control and status structs).
`default_nettype none

module ttc_month (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ttc_pkg::mon_ctl_type ctl,
   output ttc_pkg::mon_stat_type     stat
);
   import ttc_pkg::*;

   logic [3:0] mon_ff, mon_in;
   logic [8:0] doy_ff, doy_in;
   logic       leap_ff, leap_in;
   logic       busy_ff, busy_in;
   logic [4:0] len;

   assign len = month_len(mon_ff, leap_ff);

   always_comb begin
      mon_in  = mon_ff;
      doy_in  = doy_ff;
      leap_in = leap_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         mon_in  = '0;
         doy_in  = ctl.doy;
         leap_in = ctl.leap;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // December takes whatever is left
         if (mon_ff == 4'd11 || doy_ff < {4'd0, len}) begin
            busy_in = 1'b0;
         end else begin
            doy_in = doy_ff - {4'd0, len};
            mon_in = mon_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      mon_ff  <= mon_in;
      doy_ff  <= doy_in;
      leap_ff <= leap_in;
   end

   assign stat.busy         = busy_ff;
   assign stat.month_index  = mon_ff;
   assign stat.day_of_month = doy_ff[4:0] + 5'd1;

endmodule

`default_nettype wire

### rtl/core/ttc_checker.sv
// Port-level checks for the tick count to calendar converter, bound to the top level.
// No package dependency; watches the handshake and calendar result ports only.
`default_nettype none

module ttc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [8:0]                  rsp_years_since_1900,
   input wire logic [3:0]                  rsp_month_index,
   input wire logic [4:0]                  rsp_day_of_month,
   input wire logic [4:0]                  rsp_hour_of_day,
   input wire logic [5:0]                  rsp_minute_of_hour,
   input wire logic [5:0]                  rsp_second_of_minute,
   input wire logic                        rsp_out_of_range
);

   // an accepted command makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> busy)
      else $error("command accepted but busy not raised");

   // a result beat only ends a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !$past(rsp_strobe)))
      else $error("result beat without a command in flight");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |->
         (rsp_years_since_1900 == '0 && rsp_month_index == '0 && rsp_day_of_month == '0
          && rsp_hour_of_day == '0 && rsp_minute_of_hour == '0
          && rsp_second_of_minute == '0))
      else $error("out of range result with nonzero calendar fields");

   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_of_range) |->
         (rsp_month_index <= 4'd11 && rsp_day_of_month != 5'd0 && rsp_hour_of_day <= 5'd23
          && rsp_minute_of_hour <= 6'd59 && rsp_second_of_minute <= 6'd59))
      else $error("calendar field out of its range");

endmodule

bind tick_count_to_calendar ttc_checker u_ttc_checker (.*);

`default_nettype wire
